// ===== hw/rtl/b64u_pkg.sv =====
// Shared types and the character table for the base64url encoder.
// No dependencies.
package b64u_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef logic [1:0] phase_t;

  localparam phase_t PH_FIRST  = 2'd0;
  localparam phase_t PH_SECOND = 2'd1;
  localparam phase_t PH_THIRD  = 2'd2;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } qent_t;

  // 6-bit sextet to URL-safe ASCII: A-Z a-z 0-9 - _
  function automatic logic [6:0] b64u_char(input logic [5:0] v);
    logic [6:0] v7;
    logic [6:0] ch;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      ch = 7'd65 + v7;
    end else if (v < 6'd52) begin
      ch = 7'd71 + v7;
    end else if (v < 6'd62) begin
      ch = v7 - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'd45;
    end else begin
      ch = 7'd95;
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/base64url_encoder.sv =====
// Streaming base64url encoder (no padding), top level.
// Depends on b64u_pkg.
//
// One byte per request in, one ASCII character per request out. A byte
// yields one character, or two when it closes a 3-byte group or ends the
// message. Characters go into a 4-entry output queue; a byte is taken
// whenever the queue has room for two, so bytes flow at up to one per cycle
// while the output keeps up. Over full groups the one-character-per-cycle
// output port sets the pace, as three bytes give four characters, and a
// one-byte message gives two characters.
// A byte's characters are registered into the queue at the edge where the byte is taken.
// in_stall is decoded from the queue count alone.
module base64url_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic       out_last_char
);

  localparam int unsigned QAW = b64u_pkg::QAW;
  localparam int unsigned QCW = b64u_pkg::QCW;

  b64u_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       carry_r, carry_nxt;

  b64u_pkg::qent_t  q_r [b64u_pkg::QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  logic             push, pop, two;
  logic [5:0]       sx0, sx1;
  logic [QAW-1:0]   wp_p1;

  assign push      = in_valid & ~in_stall;
  assign pop       = out_valid & ~out_stall;
  assign in_stall  = (cnt_r > QCW'(b64u_pkg::QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_char_code = q_r[rp_r].code;
  assign out_last_char = q_r[rp_r].last;
  assign wp_p1     = wp_r + QAW'(1);

  always_comb begin
    sx0       = in_data_byte[7:2];
    sx1       = {in_data_byte[1:0], 4'b0000};
    two       = in_last_byte;
    phase_nxt = b64u_pkg::PH_SECOND;
    carry_nxt = {2'b00, in_data_byte[1:0]};
    case (phase_r)
      b64u_pkg::PH_SECOND: begin
        sx0       = {carry_r[1:0], in_data_byte[7:4]};
        sx1       = {in_data_byte[3:0], 2'b00};
        phase_nxt = b64u_pkg::PH_THIRD;
        carry_nxt = in_data_byte[3:0];
      end
      b64u_pkg::PH_THIRD: begin
        sx0       = {carry_r, in_data_byte[7:6]};
        sx1       = in_data_byte[5:0];
        two       = 1'b1;
        phase_nxt = b64u_pkg::PH_FIRST;
        carry_nxt = 4'd0;
      end
      default: begin
      end
    endcase
    if (in_last_byte) begin
      phase_nxt = b64u_pkg::PH_FIRST;
      carry_nxt = 4'd0;
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt  = two ? wp_r + QAW'(2) : wp_p1;
      cnt_nxt = cnt_nxt + (two ? QCW'(2) : QCW'(1));
    end
    if (pop) begin
      rp_nxt  = rp_r + QAW'(1);
      cnt_nxt = cnt_nxt - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64u_pkg::PH_FIRST;
      carry_r <= 4'd0;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      if (push) begin
        phase_r <= phase_nxt;
        carry_r <= carry_nxt;
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{code: b64u_pkg::b64u_char(sx0), last: 1'b0};
      if (two) begin
        q_r[wp_p1] <= '{code: b64u_pkg::b64u_char(sx1), last: in_last_byte};
      end
    end
  end

endmodule

// ===== hw/rtl/b64u_checker.sv =====
// Port-level checks for base64url_encoder, bound to the top level.
// Depends on base64url_encoder.
module b64u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char_code,
  input logic       out_last_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code)
      && $stable(out_last_char))
    else $error("stalled result changed");

  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code >= 7'd65 && out_char_code <= 7'd90)
      || (out_char_code >= 7'd97 && out_char_code <= 7'd122)
      || (out_char_code >= 7'd48 && out_char_code <= 7'd57)
      || out_char_code == 7'd45 || out_char_code == 7'd95))
    else $error("character outside base64url alphabet");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> out_valid)
    else $error("last byte gave no pending character");

  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output queue");

endmodule

bind base64url_encoder b64u_checker u_b64u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_last_byte  (in_last_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_code (out_char_code),
  .out_last_char (out_last_char)
);

// ===== dv/tb_top.sv =====
// Testbench for base64url_encoder: byte requests in, URL-safe characters out,
// each character checked against an in-bench encoder model or a typed-in row.
// Depends on b64u_pkg (phase codes, queue entry type) and the encoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_char_code;
  logic       out_last_char;

  base64url_encoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // Directed request: n == 0 means the characters come from the encoder model,
  // otherwise c0/l0 (and c1/l1 when n == 2) are the typed-in characters.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic [1:0] n;
    logic [7:0] c0;
    logic       l0;
    logic [7:0] c1;
    logic       l1;
  } dir_row_t;

  localparam int N_DIR = 25;

  dir_row_t dir_rows [N_DIR] = '{
    // one-byte message: two characters, low bits padded with zero
    '{8'h00, 1'b1, 2'd2, "A", 1'b0, "A", 1'b1},
    '{8'hFF, 1'b1, 2'd2, "_", 1'b0, "w", 1'b1},
    // two-byte message: three characters
    '{8'hFF, 1'b0, 2'd1, "_", 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 2'd2, "_", 1'b0, "8", 1'b1},
    // full groups; the first two messages end on the third byte, the last continues
    '{8'h00, 1'b0, 2'd1, "A", 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 2'd1, "A", 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 2'd2, "A", 1'b0, "A", 1'b1},
    '{8'hFF, 1'b0, 2'd1, "_", 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 2'd1, "_", 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 2'd2, "_", 1'b0, "_", 1'b1},
    '{8'h4D, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h61, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h6E, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    // all sextets 62 (the '-' character), message continues
    '{8'hFB, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hEF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hBE, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h01, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h03, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h0F, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hF0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h3F, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h55, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'hAA, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{8'h5A, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  b64u_pkg::qent_t  pending_chars[$];
  b64u_pkg::phase_t enc_phase;
  logic [3:0] enc_carry;
  int     mismatches;
  int     bytes_sent;
  bit     hold_req;
  int     burst_left;
  bit     bursty;

  function automatic logic [6:0] url_char(input logic [5:0] v);
    string      abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    logic [7:0] c;
    c = abc[v];
    return c[6:0];
  endfunction

  // Advances the encoder model by one byte; returns how many characters it makes.
  function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                     output b64u_pkg::qent_t r0,
                                     output b64u_pkg::qent_t r1);
    int n;
    r1 = '0;
    case (enc_phase)
      b64u_pkg::PH_SECOND: begin
        r0 = '{url_char({enc_carry[1:0], b[7:4]}), 1'b0};
        enc_carry = b[3:0];
        n = 1;
        if (fin) begin
          r1 = '{url_char({b[3:0], 2'b00}), 1'b1};
          n = 2;
        end
        enc_phase = b64u_pkg::PH_THIRD;
      end
      b64u_pkg::PH_THIRD: begin
        r0 = '{url_char({enc_carry, b[7:6]}), 1'b0};
        r1 = '{url_char(b[5:0]), fin};
        n = 2;
        enc_carry = '0;
        enc_phase = b64u_pkg::PH_FIRST;
      end
      default: begin
        r0 = '{url_char(b[7:2]), 1'b0};
        enc_carry = {2'b00, b[1:0]};
        n = 1;
        if (fin) begin
          r1 = '{url_char({b[1:0], 4'b0000}), 1'b1};
          n = 2;
        end
        enc_phase = b64u_pkg::PH_SECOND;
      end
    endcase
    if (fin) begin
      enc_phase = b64u_pkg::PH_FIRST;
      enc_carry = '0;
    end
    return n;
  endfunction

  // appends one predicted character to the tail of the pending list
  function automatic void add_char(input b64u_pkg::qent_t c);
    pending_chars = {pending_chars, c};
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Holds the request until taken; returns at the edge where it is accepted.
  task automatic offer(input logic [7:0] b, input logic fin);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic idle(input int cycles);
    in_valid     <= 1'b0;
    in_data_byte <= 8'($urandom);
    in_last_byte <= 1'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic fin);
    b64u_pkg::qent_t r0, r1;
    int    n;
    offer(b, fin);
    n = encode_byte(b, fin, r0, r1);
    add_char(r0);
    if (n == 2) add_char(r1);
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        idle($urandom_range(1, 6));
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_message(input int len);
    for (int k = 0; k < len; k++) begin
      send_predicted(8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("base64url_encoder: mismatch");
    $finish;
  end

  // receiver: mode changes every so often, plus an occasional long hold-off
  initial begin
    int hold_cnt;
    int stall_mode;
    int mode_left;
    int tick;
    hold_cnt   = 0;
    stall_mode = 0;
    mode_left  = 0;
    tick       = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 80;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= (tick % 3 == 0);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    b64u_pkg::qent_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", out_char_code,
                         out_last_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code)
          report($sformatf("char_code 0x%02h, want 0x%02h", out_char_code, want.code));
        if (out_last_char !== want.last)
          report($sformatf("last_char %0b, want %0b", out_last_char, want.last));
      end
    end
  end

  initial begin
    b64u_pkg::qent_t r0, r1;
    int    n;
    int    next_drain;
    int    len;
    mismatches   = 0;
    bytes_sent   = 0;
    hold_req     = 1'b0;
    burst_left   = 0;
    bursty       = 1'b0;
    enc_phase    = b64u_pkg::PH_FIRST;
    enc_carry    = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      offer(dir_rows[i].b, dir_rows[i].fin);
      n = encode_byte(dir_rows[i].b, dir_rows[i].fin, r0, r1);
      if (dir_rows[i].n != 2'd0) begin
        r0 = '{dir_rows[i].c0[6:0], dir_rows[i].l0};
        r1 = '{dir_rows[i].c1[6:0], dir_rows[i].l1};
        n  = int'(dir_rows[i].n);
      end
      add_char(r0);
      if (n == 2) add_char(r1);
    end
    drain();

    // long receiver hold-off while requests keep coming: queue fills, input stalls
    hold_req = 1'b1;
    bursty   = 1'b0;
    send_message(30);
    drain();

    next_drain = bytes_sent + $urandom_range(150, 300);
    while (bytes_sent < 1690) begin
      bursty = ($urandom_range(0, 9) >= 3);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(41, 64);
        1, 2, 3: len = $urandom_range(10, 40);
        default: len = $urandom_range(1, 9);
      endcase
      send_message(len);
      if (bytes_sent >= next_drain) begin
        if ($urandom_range(0, 3) == 0) hold_req = 1'b1;
        drain();
        next_drain = bytes_sent + $urandom_range(150, 300);
      end else if ($urandom_range(0, 1) == 0) begin
        idle($urandom_range(1, 8));
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("base64url_encoder: match");
    end else begin
      $display("base64url_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/b64u_pkg.sv
hw/rtl/base64url_encoder.sv
hw/rtl/b64u_checker.sv
dv/tb_top.sv
